### rtl/dfma_pkg.sv
// ----------------------------------------------------------------------------
// dfma_pkg: shared types and constants for the binary64 fused multiply-add
// Holds the IEEE 754 binary64 encoding constants, the leading-one search
// and the transaction record passed from the datapath to the rounding stages.
// ----------------------------------------------------------------------------
package dfma_pkg;

    localparam logic [63:0] INF_BITS    = 64'h7FF0_0000_0000_0000;
    localparam logic [63:0] QUIET_BIT   = 64'h0008_0000_0000_0000;
    localparam logic [63:0] DEFAULT_NAN = 64'hFFF8_0000_0000_0000;
    localparam logic [10:0] EXP_ALL_ONE = 11'h7FF;

    // Exponent arithmetic is carried in 14-bit two's complement.
    typedef logic signed [13:0] dfma_exp_t;

    // One transaction on its way into the rounding pipeline.
    typedef struct packed {
        logic         valid;
        logic         last;
        logic         bypass;
        logic [63:0]  bypass_val;
        logic         sign;
        logic [127:0] mag;
        dfma_exp_t    exp;
    } dfma_rnd_t;

    // Index of the most significant set bit; zero when the word is zero.
    function automatic logic [6:0] dfma_top(input logic [127:0] x);
        logic [6:0] t;
        t = 7'd0;
        for (int i = 0; i < 128; i++) begin
            if (x[i]) begin
                t = 7'(i);
            end
        end
        return t;
    endfunction

endpackage

### rtl/dfma_round.sv
// ----------------------------------------------------------------------------
// dfma_round: normalise and round to binary64
// Four register stages: leading-one search, exponent and tiny detection,
// shift with guard and sticky, then increment, overflow check and packing.
// ----------------------------------------------------------------------------
module dfma_round
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  dfma_pkg::dfma_rnd_t  rin,
    output logic [63:0]          sum_bits,
    output logic                 last_out,
    output logic                 done
);
    import dfma_pkg::*;

    localparam dfma_exp_t EMIN_SUB = -14'sd1074;
    localparam dfma_exp_t BIAS     = 14'sd1023;
    localparam dfma_exp_t EMAX_B   = 14'sd2046;

    // Stage A: leading one of the magnitude.
    dfma_rnd_t  a_reg;
    logic [6:0] a_top_reg;

    // Stage B: shift amount, tiny flag and biased exponent.
    dfma_rnd_t  b_reg;
    dfma_exp_t  b_shift_reg;
    dfma_exp_t  b_bexp_reg;
    logic       b_tiny_reg;

    // Stage C: truncated significand and round-up decision.
    logic        c_valid_reg;
    logic        c_last_reg;
    logic        c_bypass_reg;
    logic [63:0] c_bypass_val_reg;
    logic        c_sign_reg;
    logic [63:0] c_q_reg;
    logic        c_inc_reg;
    logic        c_tiny_reg;
    dfma_exp_t   c_bexp_reg;

    logic [63:0] sum_bits_reg;
    logic        last_out_reg;
    logic        done_reg;

    dfma_exp_t   b_s_next;
    dfma_exp_t   b_lim_next;
    dfma_exp_t   b_top_s;

    logic [63:0] c_q_next;
    logic        c_inc_next;
    logic [6:0]  c_sh;
    logic [6:0]  c_shm1;
    logic [127:0] c_qw;
    logic [127:0] c_mask;

    logic [63:0] o_qr;
    logic [63:0] o_enc;
    logic [63:0] o_exp_field;
    logic [63:0] sum_bits_next;

    // Stage A and B records carry their valid bits; later valid bits follow.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_reg       <= '0;
            b_reg       <= '0;
            c_valid_reg <= 1'b0;
            done_reg    <= 1'b0;
        end
        else
        begin
            a_reg       <= rin;
            b_reg       <= a_reg;
            c_valid_reg <= b_reg.valid;
            done_reg    <= c_valid_reg;
        end
    end

    // Stage B logic: choose the rounding position.
    always_comb
    begin
        b_top_s    = dfma_exp_t'({7'd0, a_top_reg});
        b_s_next   = b_top_s - 14'sd52;
        b_lim_next = EMIN_SUB - a_reg.exp;
    end

    // Stage C logic: shift right, keeping guard and sticky.
    always_comb
    begin
        c_sh     = b_shift_reg[6:0];
        c_shm1   = c_sh - 7'd1;
        c_qw     = b_reg.mag >> c_sh;
        c_mask   = (128'd1 << c_shm1) - 128'd1;
        c_q_next = 64'd0;
        c_inc_next = 1'b0;
        if (b_shift_reg <= 14'sd0)
        begin
            c_q_next = 64'(b_reg.mag << (7'(-b_shift_reg)));
        end
        else if (b_shift_reg >= 14'sd128)
        begin
            c_q_next = 64'd0;
        end
        else
        begin
            c_q_next   = c_qw[63:0];
            c_inc_next = b_reg.mag[c_shm1] &&
                         (((b_reg.mag & c_mask) != 128'd0) || c_qw[0]);
        end
    end

    // Output stage logic: increment and pack.
    always_comb
    begin
        o_qr        = c_q_reg + {63'd0, c_inc_reg};
        o_exp_field = {c_bexp_reg[11:0] - 12'd1, 52'd0};
        if (c_tiny_reg)
        begin
            o_enc = o_qr;
        end
        else if (c_bexp_reg > EMAX_B)
        begin
            o_enc = INF_BITS;
        end
        else
        begin
            o_enc = o_exp_field + o_qr;
        end
        if (o_enc >= INF_BITS)
        begin
            o_enc = INF_BITS;
        end
        if (c_bypass_reg)
        begin
            sum_bits_next = c_bypass_val_reg;
        end
        else
        begin
            sum_bits_next = {c_sign_reg, 63'd0} | o_enc;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        a_top_reg        <= dfma_top(rin.mag);

        b_tiny_reg       <= (b_lim_next > b_s_next);
        b_shift_reg      <= (b_lim_next > b_s_next) ? b_lim_next : b_s_next;
        b_bexp_reg       <= b_top_s + a_reg.exp + BIAS;

        c_last_reg       <= b_reg.last;
        c_bypass_reg     <= b_reg.bypass;
        c_bypass_val_reg <= b_reg.bypass_val;
        c_sign_reg       <= b_reg.sign;
        c_q_reg          <= c_q_next;
        c_inc_reg        <= c_inc_next;
        c_tiny_reg       <= b_tiny_reg;
        c_bexp_reg       <= b_bexp_reg;

        sum_bits_reg     <= sum_bits_next;
        last_out_reg     <= c_last_reg;
    end

    assign sum_bits = sum_bits_reg;
    assign last_out = last_out_reg;
    assign done     = done_reg;

endmodule

### rtl/double_fused_multiply_add_top.sv
// ----------------------------------------------------------------------------
// double_fused_multiply_add_top: pipelined binary64 fused multiply-add
// Computes a*b+c with a single round-to-nearest-even rounding.
// ----------------------------------------------------------------------------
// A transaction is taken whenever start is high; busy is always low, so a new
// element triple may be presented on every cycle. Each result appears on
// sum_bits and last_out for exactly one cycle, marked by done, in issue
// order; the receiver must take it then, as nothing is held back.
// Throughput is one transaction per cycle, through eleven register
// stages: split 53x53 multiply, partial-product sum, two normalise stages,
// operand swap, alignment, add/subtract, and the four rounding stages.
module double_fused_multiply_add_top
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [63:0] a_bits,
    input  logic [63:0] b_bits,
    input  logic [63:0] c_bits,
    input  logic        last_in,
    output logic [63:0] sum_bits,
    output logic        last_out,
    output logic        done
);
    import dfma_pkg::*;

    // Input decode.
    logic        sa, sb, sc, sp;
    logic [10:0] xa, xb, xc, xa1, xb1, xc1;
    logic        za, zb, zc;
    logic        nan_a, nan_b, nan_c;
    logic [52:0] ma, mb, mc;
    logic        spec_next;
    logic [63:0] spec_val_next;

    // Stage 1: partial products and special cases.
    logic        v1_reg;
    logic [53:0] pp_hh_reg;
    logic [52:0] pp_hl_reg, pp_lh_reg;
    logic [51:0] pp_ll_reg;
    logic [11:0] s1_xsum_reg;
    logic        s1_sp_reg, s1_sc_reg, s1_zc_reg, s1_last_reg, s1_spec_reg;
    logic [63:0] s1_spec_val_reg;
    logic [52:0] s1_mc_reg;
    logic [10:0] s1_xc_reg;

    // Stage 2: full product, normalised addend.
    logic         v2_reg;
    logic [105:0] s2_p_reg;
    logic [127:0] s2_cw_reg;
    dfma_exp_t    s2_ec_reg;
    logic [11:0]  s2_xsum_reg;
    logic         s2_sp_reg, s2_sc_reg, s2_zc_reg, s2_last_reg, s2_spec_reg;
    logic [63:0]  s2_spec_val_reg;
    logic [6:0]   s2_tc;

    // Stage 3: product leading one.
    logic         v3_reg;
    logic [105:0] s3_p_reg;
    logic [6:0]   s3_tp_reg;
    logic [127:0] s3_cw_reg;
    dfma_exp_t    s3_ec_reg;
    logic [11:0]  s3_xsum_reg;
    logic         s3_sp_reg, s3_sc_reg, s3_zc_reg, s3_last_reg, s3_spec_reg;
    logic [63:0]  s3_spec_val_reg;

    // Stage 4: normalised product.
    logic         v4_reg;
    logic [127:0] s4_p_reg;
    dfma_exp_t    s4_ep_reg;
    logic [127:0] s4_cw_reg;
    dfma_exp_t    s4_ec_reg;
    logic         s4_sp_reg, s4_sc_reg, s4_zc_reg, s4_last_reg, s4_spec_reg;
    logic [63:0]  s4_spec_val_reg;
    logic [6:0]   s4_sh;

    // Stage 5: larger and smaller operand.
    logic         v5_reg;
    logic [127:0] s5_big_reg, s5_small_reg;
    logic [13:0]  s5_d_reg;
    dfma_exp_t    s5_e_reg;
    logic         s5_sign_reg, s5_sub_reg, s5_last_reg, s5_spec_reg;
    logic [63:0]  s5_spec_val_reg;
    logic         s5_pbig;
    dfma_exp_t    s5_diff;

    // Stage 6: aligned smaller operand.
    logic         v6_reg;
    logic [127:0] s6_big_reg, s6_small_reg;
    dfma_exp_t    s6_e_reg;
    logic         s6_sign_reg, s6_sub_reg, s6_last_reg, s6_spec_reg;
    logic [63:0]  s6_spec_val_reg;
    logic [127:0] s6_small_next;
    logic [6:0]   s6_d7;

    // Stage 7: sum, handed to the rounder.
    dfma_rnd_t    s7_reg;
    logic [127:0] s7_r;

    assign busy = 1'b0;

    // Decode the operands and resolve special cases.
    always_comb
    begin
        sa = a_bits[63];
        sb = b_bits[63];
        sc = c_bits[63];
        sp = sa ^ sb;
        xa = a_bits[62:52];
        xb = b_bits[62:52];
        xc = c_bits[62:52];
        za = (a_bits[62:0] == 63'd0);
        zb = (b_bits[62:0] == 63'd0);
        zc = (c_bits[62:0] == 63'd0);
        nan_a = (xa == EXP_ALL_ONE) && (a_bits[51:0] != 52'd0);
        nan_b = (xb == EXP_ALL_ONE) && (b_bits[51:0] != 52'd0);
        nan_c = (xc == EXP_ALL_ONE) && (c_bits[51:0] != 52'd0);
        ma  = {xa != 11'd0, a_bits[51:0]};
        mb  = {xb != 11'd0, b_bits[51:0]};
        mc  = {xc != 11'd0, c_bits[51:0]};
        xa1 = (xa == 11'd0) ? 11'd1 : xa;
        xb1 = (xb == 11'd0) ? 11'd1 : xb;
        xc1 = (xc == 11'd0) ? 11'd1 : xc;

        spec_next     = 1'b1;
        spec_val_next = 64'd0;
        if (nan_a)
        begin
            spec_val_next = a_bits | QUIET_BIT;
        end
        else if (nan_b)
        begin
            spec_val_next = b_bits | QUIET_BIT;
        end
        else if (nan_c)
        begin
            spec_val_next = c_bits | QUIET_BIT;
        end
        else if ((xa == EXP_ALL_ONE) || (xb == EXP_ALL_ONE))
        begin
            if (za || zb)
            begin
                spec_val_next = DEFAULT_NAN;
            end
            else if ((xc == EXP_ALL_ONE) && (sc != sp))
            begin
                spec_val_next = DEFAULT_NAN;
            end
            else
            begin
                spec_val_next = {sp, 63'd0} | INF_BITS;
            end
        end
        else if (xc == EXP_ALL_ONE)
        begin
            spec_val_next = c_bits;
        end
        else if (za || zb)
        begin
            if (!zc)
            begin
                spec_val_next = c_bits;
            end
            else
            begin
                spec_val_next = {sp & sc, 63'd0};
            end
        end
        else
        begin
            spec_next = 1'b0;
        end
    end

    // Stage 2 logic: normalise the addend to bit 125.
    assign s2_tc = dfma_top({75'd0, s1_mc_reg});

    // Stage 4 logic: product normalising shift.
    assign s4_sh = 7'd125 - s3_tp_reg;

    // Stage 5 logic: order operands by magnitude.
    always_comb
    begin
        s5_diff = s4_ep_reg - s4_ec_reg;
        s5_pbig = s4_zc_reg || (s4_ep_reg > s4_ec_reg) ||
                  ((s4_ep_reg == s4_ec_reg) && (s4_p_reg >= s4_cw_reg));
    end

    // Stage 6 logic: shift right with sticky jam.
    always_comb
    begin
        s6_d7 = s5_d_reg[6:0];
        if (s5_d_reg[13:7] != 7'd0)
        begin
            s6_small_next = {127'd0, s5_small_reg != 128'd0};
        end
        else
        begin
            s6_small_next = s5_small_reg >> s6_d7;
            if ((s5_small_reg & ((128'd1 << s6_d7) - 128'd1)) != 128'd0)
            begin
                s6_small_next[0] = 1'b1;
            end
        end
    end

    // Stage 7 logic: effective add or subtract.
    assign s7_r = s6_sub_reg ? (s6_big_reg - s6_small_reg) : (s6_big_reg + s6_small_reg);

    // Valid bits, and the stage 7 record that travels with its valid bit.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
            s7_reg <= '0;
        end
        else
        begin
            v1_reg       <= start && !busy;
            v2_reg       <= v1_reg;
            v3_reg       <= v2_reg;
            v4_reg       <= v3_reg;
            v5_reg       <= v4_reg;
            v6_reg       <= v5_reg;
            s7_reg.valid <= v6_reg;

            // An exact cancellation gives positive zero.
            s7_reg.last       <= s6_last_reg;
            s7_reg.bypass     <= s6_spec_reg || (s6_sub_reg && (s7_r == 128'd0));
            s7_reg.bypass_val <= s6_spec_reg ? s6_spec_val_reg : 64'd0;
            s7_reg.sign       <= s6_sign_reg;
            s7_reg.mag        <= s7_r;
            s7_reg.exp        <= s6_e_reg;
        end
    end

    // Datapath registers, stages 1 to 6.
    always_ff @(posedge clk)
    begin
        pp_hh_reg       <= 54'(ma[52:26]) * 54'(mb[52:26]);
        pp_hl_reg       <= 53'(ma[52:26]) * 53'(mb[25:0]);
        pp_lh_reg       <= 53'(ma[25:0]) * 53'(mb[52:26]);
        pp_ll_reg       <= 52'(ma[25:0]) * 52'(mb[25:0]);
        s1_xsum_reg     <= {1'b0, xa1} + {1'b0, xb1};
        s1_sp_reg       <= sp;
        s1_sc_reg       <= sc;
        s1_zc_reg       <= zc;
        s1_mc_reg       <= mc;
        s1_xc_reg       <= xc1;
        s1_last_reg     <= last_in;
        s1_spec_reg     <= spec_next;
        s1_spec_val_reg <= spec_val_next;

        s2_p_reg        <= ({52'd0, pp_hh_reg} << 52)
                         + (({53'd0, pp_hl_reg} + {53'd0, pp_lh_reg}) << 26)
                         + {54'd0, pp_ll_reg};
        s2_cw_reg       <= {75'd0, s1_mc_reg} << (7'd125 - s2_tc);
        s2_ec_reg       <= dfma_exp_t'({3'd0, s1_xc_reg}) - 14'sd1075
                         - (14'sd125 - dfma_exp_t'({7'd0, s2_tc}));
        s2_xsum_reg     <= s1_xsum_reg;
        s2_sp_reg       <= s1_sp_reg;
        s2_sc_reg       <= s1_sc_reg;
        s2_zc_reg       <= s1_zc_reg;
        s2_last_reg     <= s1_last_reg;
        s2_spec_reg     <= s1_spec_reg;
        s2_spec_val_reg <= s1_spec_val_reg;

        s3_p_reg        <= s2_p_reg;
        s3_tp_reg       <= dfma_top({22'd0, s2_p_reg});
        s3_cw_reg       <= s2_cw_reg;
        s3_ec_reg       <= s2_ec_reg;
        s3_xsum_reg     <= s2_xsum_reg;
        s3_sp_reg       <= s2_sp_reg;
        s3_sc_reg       <= s2_sc_reg;
        s3_zc_reg       <= s2_zc_reg;
        s3_last_reg     <= s2_last_reg;
        s3_spec_reg     <= s2_spec_reg;
        s3_spec_val_reg <= s2_spec_val_reg;

        s4_p_reg        <= {22'd0, s3_p_reg} << s4_sh;
        s4_ep_reg       <= dfma_exp_t'({2'd0, s3_xsum_reg}) - 14'sd2150
                         - dfma_exp_t'({7'd0, s4_sh});
        s4_cw_reg       <= s3_cw_reg;
        s4_ec_reg       <= s3_ec_reg;
        s4_sp_reg       <= s3_sp_reg;
        s4_sc_reg       <= s3_sc_reg;
        s4_zc_reg       <= s3_zc_reg;
        s4_last_reg     <= s3_last_reg;
        s4_spec_reg     <= s3_spec_reg;
        s4_spec_val_reg <= s3_spec_val_reg;

        s5_big_reg      <= s5_pbig ? s4_p_reg : s4_cw_reg;
        s5_small_reg    <= s4_zc_reg ? 128'd0 : (s5_pbig ? s4_cw_reg : s4_p_reg);
        s5_d_reg        <= s4_zc_reg ? 14'd0 : (s5_pbig ? s5_diff : -s5_diff);
        s5_e_reg        <= s5_pbig ? s4_ep_reg : s4_ec_reg;
        s5_sign_reg     <= s5_pbig ? s4_sp_reg : s4_sc_reg;
        s5_sub_reg      <= !s4_zc_reg && (s4_sp_reg != s4_sc_reg);
        s5_last_reg     <= s4_last_reg;
        s5_spec_reg     <= s4_spec_reg;
        s5_spec_val_reg <= s4_spec_val_reg;

        s6_big_reg      <= s5_big_reg;
        s6_small_reg    <= s6_small_next;
        s6_e_reg        <= s5_e_reg;
        s6_sign_reg     <= s5_sign_reg;
        s6_sub_reg      <= s5_sub_reg;
        s6_last_reg     <= s5_last_reg;
        s6_spec_reg     <= s5_spec_reg;
        s6_spec_val_reg <= s5_spec_val_reg;
    end

    // Rounding and packing.
    dfma_round u_round
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .rin      (s7_reg),
        .sum_bits (sum_bits),
        .last_out (last_out),
        .done     (done)
    );

endmodule
